/* hw/rtl/ipc_pkg.sv */
package ipc_pkg;

  localparam int unsigned MaxWidth  = 64;
  localparam int unsigned MaxHeight = 64;

  localparam int unsigned ColW   = $clog2(MaxWidth);
  localparam int unsigned RowW   = $clog2(MaxHeight);
  localparam int unsigned DimW   = 7;
  localparam int unsigned CountW = 13;
  localparam int unsigned LineW  = 2;

  localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};

  // Frame size out of reset is 10x10, clamped to the maximum.
  localparam int unsigned ResetDim       = 10;
  localparam int unsigned ResetWidthUse  = (ResetDim > MaxWidth)  ? MaxWidth  : ResetDim;
  localparam int unsigned ResetHeightUse = (ResetDim > MaxHeight) ? MaxHeight : ResetDim;
  localparam logic [ColW-1:0] ResetLastCol = ColW'(ResetWidthUse - 1);
  localparam logic [RowW-1:0] ResetLastRow = RowW'(ResetHeightUse - 1);

  localparam int unsigned CfgIdxW = 2;

  typedef enum logic [CfgIdxW-1:0] {
    CfgFrameWidth  = 2'd0,
    CfgFrameHeight = 2'd1
  } cfg_reg_e;

  // Pixel in flight between RAM read and write-back.
  typedef struct packed {
    logic             pix;
    logic             row_ge1;
    logic             row_ge2;
    logic             col_ge1;
    logic             col_ge2;
    logic             last_row;
    logic             last_col;
    logic [ColW-1:0]  col;
    logic             fwd;
    logic [LineW-1:0] fwd_data;
  } s1_t;

endpackage

/* hw/rtl/ipc_pix_if.sv */
interface ipc_pix_if;
  logic valid;
  logic ready;
  logic pixel_bit;

  modport source (output valid, output pixel_bit, input ready);
  modport sink   (input valid, input pixel_bit, output ready);
endinterface

/* hw/rtl/ipc_cnt_if.sv */
interface ipc_cnt_if;
  logic                        valid;
  logic                        ready;
  logic [ipc_pkg::CountW-1:0]  isolated_count;

  modport source (output valid, output isolated_count, input ready);
  modport sink   (input valid, input isolated_count, output ready);
endinterface

/* hw/rtl/ipc_cfg_if.sv */
interface ipc_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [ipc_pkg::CfgIdxW-1:0]  index;
  logic [ipc_pkg::DimW-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* hw/rtl/ipc_ram.sv */
// Simple dual-port RAM, registered read, old data on read-during-write.
module ipc_ram #(
  parameter int unsigned Width = 2,
  parameter int unsigned Depth = 64,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/isolated_pixel_counter.sv */
// Isolated pixel counter, 8-connected. Pixels enter one per beat in raster
// order and the block counts set pixels whose eight neighbors are clear or
// off the frame; at the last pixel of each frame one beat carries the count
// and a new frame starts at zero. The sustained rate is one pixel per clock:
// each pixel does one read and one write of a 64x2 line-store RAM (the two
// rows above, per column) and a 3x3 window is kept in flops. The last pixel's
// count passes stage 1, then the output buffer. Counts queue in a two-entry
// output buffer, so the last pixel of a frame is held off only while two
// counts are already queued or on their way; with the receiver ready, even
// single-pixel frames run at one pixel per clock. Frame width and height are
// clamped to 1..64 (zero acts as one); any write to either register restarts
// the frame, and writes are expected only with the block idle. The RAM needs
// no clearing after reset: rows above the top and columns left of the edge
// are masked by position.
module isolated_pixel_counter (
  input  logic   clk_i,
  input  logic   rst_ni,
  ipc_pix_if.sink   pix_i,
  ipc_cfg_if.sink   cfg_i,
  ipc_cnt_if.source cnt_o
);

  localparam int unsigned ColW   = ipc_pkg::ColW;
  localparam int unsigned RowW   = ipc_pkg::RowW;
  localparam int unsigned CountW = ipc_pkg::CountW;
  localparam int unsigned LineW  = ipc_pkg::LineW;

  // ---------------- configuration ----------------
  logic [ColW-1:0] w_last_q, w_last_d;
  logic [RowW-1:0] h_last_q, h_last_d;
  logic            cfg_hit;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    w_last_d = w_last_q;
    h_last_d = h_last_q;
    cfg_hit  = 1'b0;
    if (cfg_i.valid) begin
      case (cfg_i.index)
        ipc_pkg::CfgFrameWidth: begin
          cfg_hit = 1'b1;
          if (cfg_i.data == '0) begin
            w_last_d = '0;
          end else if (32'(cfg_i.data) > ipc_pkg::MaxWidth) begin
            w_last_d = ColW'(ipc_pkg::MaxWidth - 1);
          end else begin
            w_last_d = ColW'(cfg_i.data - 1'b1);
          end
        end
        ipc_pkg::CfgFrameHeight: begin
          cfg_hit = 1'b1;
          if (cfg_i.data == '0) begin
            h_last_d = '0;
          end else if (32'(cfg_i.data) > ipc_pkg::MaxHeight) begin
            h_last_d = RowW'(ipc_pkg::MaxHeight - 1);
          end else begin
            h_last_d = RowW'(cfg_i.data - 1'b1);
          end
        end
        default: begin
          cfg_hit = 1'b0;  // unknown index, dropped
        end
      endcase
    end
  end

  // ---------------- stage 0: position, RAM read issue ----------------
  logic [ColW-1:0] col_q, col_d;
  logic [RowW-1:0] row_q, row_d;
  logic            at_last_col, at_last_row, at_last_pix;
  logic            in_ready, in_fire;

  logic            s1_valid_q;
  ipc_pkg::s1_t    s1_q, s1_d;
  logic            s1_res;

  logic              out_valid_q, out_valid_d;
  logic [CountW-1:0] out_cnt_q, out_cnt_d;
  logic              skid_valid_q, skid_valid_d;
  logic [CountW-1:0] skid_cnt_q, skid_cnt_d;

  assign at_last_col = (col_q == w_last_q);
  assign at_last_row = (row_q == h_last_q);
  assign at_last_pix = at_last_col && at_last_row;

  // The last pixel must find a free output entry when it retires.
  assign in_ready    = !at_last_pix || !skid_valid_d;
  assign pix_i.ready = in_ready;
  assign in_fire     = pix_i.valid && in_ready;

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (in_fire) begin
      if (at_last_pix) begin
        col_d = '0;
        row_d = '0;
      end else if (at_last_col) begin
        col_d = '0;
        row_d = row_q + RowW'(1);
      end else begin
        col_d = col_q + ColW'(1);
      end
    end
    if (cfg_hit) begin
      col_d = '0;
      row_d = '0;
    end
  end

  // ---------------- line store ----------------
  logic [LineW-1:0] ram_rdata, line_rd, ram_wdata;

  ipc_ram #(
    .Width (LineW),
    .Depth (ipc_pkg::MaxWidth)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (s1_valid_q),
    .waddr_i (s1_q.col),
    .wdata_i (ram_wdata),
    .re_i    (in_fire),
    .raddr_i (col_q),
    .rdata_o (ram_rdata)
  );

  // bit 0: row above, bit 1: two rows above
  assign line_rd   = s1_q.fwd ? s1_q.fwd_data : ram_rdata;
  assign ram_wdata = {line_rd[0], s1_q.pix};

  always_comb begin
    s1_d          = s1_q;
    s1_d.pix      = pix_i.pixel_bit;
    s1_d.row_ge1  = (row_q != '0);
    s1_d.row_ge2  = (row_q > RowW'(1));
    s1_d.col_ge1  = (col_q != '0);
    s1_d.col_ge2  = (col_q > ColW'(1));
    s1_d.last_row = at_last_row;
    s1_d.last_col = at_last_col;
    s1_d.col      = col_q;
    // Same column written this cycle (one-column frames): RAM returns old data.
    s1_d.fwd      = s1_valid_q && (s1_q.col == col_q);
    s1_d.fwd_data = ram_wdata;
  end

  // ---------------- stage 1: window, decisions, write-back ----------------
  // column vectors: [0] two rows up, [1] row up, [2] current row
  logic [2:0] win_c1_q, win_c2_q;
  logic [2:0] va, vb, vd;
  logic       dec_ul, dec_ur, dec_ll, dec_lr;
  logic [2:0] add;
  logic [CountW:0]   cnt_sum;
  logic [CountW-1:0] cnt_q, cnt_d, cnt_sat;

  assign vd = {s1_q.pix, line_rd[0] & s1_q.row_ge1, line_rd[1] & s1_q.row_ge2};
  assign vb = win_c1_q & {3{s1_q.col_ge1}};
  assign va = win_c2_q & {3{s1_q.col_ge2}};

  assign s1_res = s1_valid_q && s1_q.last_row && s1_q.last_col;

  // Pixel up-left: full window available.
  assign dec_ul = s1_q.row_ge1 && s1_q.col_ge1 && vb[1] && (va == '0) && !vb[0]
                  && !vb[2] && (vd == '0);
  // Pixel up, at the right edge.
  assign dec_ur = s1_q.row_ge1 && s1_q.last_col && vd[1] && (vb == '0)
                  && !vd[0] && !vd[2];
  // Pixel left, in the bottom row.
  assign dec_ll = s1_q.last_row && s1_q.col_ge1 && vb[2] && !va[1] && !va[2]
                  && !vb[1] && !vd[1] && !vd[2];
  // Current pixel, bottom-right corner.
  assign dec_lr = s1_q.last_row && s1_q.last_col && vd[2] && !vb[1] && !vb[2]
                  && !vd[1];

  assign add     = 3'(dec_ul) + 3'(dec_ur) + 3'(dec_ll) + 3'(dec_lr);
  assign cnt_sum = {1'b0, cnt_q} + (CountW + 1)'(add);
  assign cnt_sat = (cnt_sum > {1'b0, ipc_pkg::CountMax}) ? ipc_pkg::CountMax
                                                         : cnt_sum[CountW-1:0];

  always_comb begin
    cnt_d        = cnt_q;
    out_valid_d  = out_valid_q;
    out_cnt_d    = out_cnt_q;
    skid_valid_d = skid_valid_q;
    skid_cnt_d   = skid_cnt_q;
    // Head beat taken: the spare entry, if any, moves up.
    if (out_valid_q && cnt_o.ready) begin
      out_valid_d  = skid_valid_q;
      out_cnt_d    = skid_cnt_q;
      skid_valid_d = 1'b0;
    end
    if (s1_valid_q) begin
      if (s1_res) begin
        cnt_d = '0;
        if (!out_valid_d) begin
          out_valid_d = 1'b1;
          out_cnt_d   = cnt_sat;
        end else begin
          skid_valid_d = 1'b1;
          skid_cnt_d   = cnt_sat;
        end
      end else begin
        cnt_d = cnt_sat;
      end
    end
    if (cfg_hit) begin
      cnt_d = '0;
    end
  end

  assign cnt_o.valid          = out_valid_q;
  assign cnt_o.isolated_count = out_cnt_q;

  // ---------------- registers ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_last_q     <= ipc_pkg::ResetLastCol;
      h_last_q     <= ipc_pkg::ResetLastRow;
      col_q        <= '0;
      row_q        <= '0;
      s1_valid_q   <= 1'b0;
      win_c1_q     <= '0;
      win_c2_q     <= '0;
      cnt_q        <= '0;
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      w_last_q     <= w_last_d;
      h_last_q     <= h_last_d;
      col_q        <= col_d;
      row_q        <= row_d;
      s1_valid_q   <= in_fire;
      cnt_q        <= cnt_d;
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
      if (cfg_hit) begin
        win_c1_q <= '0;
        win_c2_q <= '0;
      end else if (s1_valid_q) begin
        win_c2_q <= vb;
        win_c1_q <= vd;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_q <= s1_d;
    end
    out_cnt_q  <= out_cnt_d;
    skid_cnt_q <= skid_cnt_d;
  end

  // ---------------- assertions ----------------
  // A count never arrives with both output entries taken.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_res |-> !skid_valid_q)
    else $error("result buffer overwritten");

  // The spare entry only fills behind a waiting head beat.
  a_skid_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("spare entry valid with empty head");

  // Forwarding is only needed when a row is one column wide.
  a_fwd_narrow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && s1_q.fwd) |-> (w_last_q == '0))
    else $error("forward hit on a frame wider than one column");

  // Position stays inside the frame in use.
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (col_q <= w_last_q) && (row_q <= h_last_q))
    else $error("pixel position outside frame");

  // Count restarts after the frame result is taken into the output buffer.
  a_cnt_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_res |=> (cnt_q == '0) && out_valid_q)
    else $error("count not restarted at frame end");

endmodule
